### design/lfu_dir_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the LFU replacement directory.
// No dependencies; every other design file refers to it by scoped names.
package lfu_dir_pkg;

    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam int CFG_W      = 7;
    localparam int CMP_W      = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int KEY_W      = 64;
    localparam int ACTION_W   = 2;
    localparam int SLOT_W     = 6;
    localparam int USE_W      = 16;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [OCC_W-1:0]      occ_t;
    typedef logic [CFG_W-1:0]      cfg_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [USE_W-1:0]      use_t;

    localparam cfg_t   CAP_RESET = CFG_W'(64);
    localparam count_t COUNT_MAX = '1;
    localparam use_t   USE_MAX   = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIND   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RANK,
        ST_WRITE,
        ST_RESULT
    } state_t;

    // Slot index into the slot field: low bits, zero-extended where narrower
    function automatic slot_t slot_field(idx_t i);
        logic [IDX_W+SLOT_W-1:0] w;
        w = (IDX_W + SLOT_W)'(i);
        return w[SLOT_W-1:0];
    endfunction

    // Count into the use_count field, saturating
    function automatic use_t use_field(count_t c);
        logic [COUNT_BITS+USE_W-1:0] w;
        w = (COUNT_BITS + USE_W)'(c);
        return (w > (COUNT_BITS + USE_W)'(USE_MAX)) ? USE_MAX : w[USE_W-1:0];
    endfunction

endpackage

### design/lfu_dir_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying action and key.
// Depends on lfu_dir_pkg.
interface lfu_dir_req_if;
    logic                             valid;
    logic                             ready;
    logic [lfu_dir_pkg::ACTION_W-1:0] action;
    lfu_dir_pkg::key_t                key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

### design/lfu_dir_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one result per request.
// Depends on lfu_dir_pkg.
interface lfu_dir_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    lfu_dir_pkg::slot_t slot;
    lfu_dir_pkg::use_t  use_count;
    logic               evicted;
    lfu_dir_pkg::key_t  evicted_key;

    modport source (output valid, output hit, output slot, output use_count,
                    output evicted, output evicted_key, input ready);
    modport sink   (input valid, input hit, input slot, input use_count,
                    input evicted, input evicted_key, output ready);
endinterface

### design/lfu_replacement_directory_unit.sv
`timescale 1ns / 1ps
// Keyed directory with least-frequently-used replacement (top level).
// Depends on lfu_dir_pkg, lfu_dir_req_if and lfu_dir_rsp_if.
//
// Usage: each req transaction carries a find, add or remove of a 64-bit key;
// each one yields exactly one rsp transaction (hit, slot, use_count, evicted,
// evicted_key). cfg_we/cfg_wdata set capacity_limit; the user must write it
// only while idle, which the block itself does not enforce.
// Timing: one request at a time; req.ready is high only when idle. A request
// walks all ENTRIES slots through one read port of the entry memories to find
// the key, the first free slot and the LFU/oldest victim, then passes through
// a decide state. A hit, remove or eviction adds a second walk over the
// recency memory to close the rank gap; an insert adds a write state; the
// result state then loads the result register.
// The result register holds until taken; if the previous result still waits
// when the next one is ready, the block stalls in its result state.
// Reset: all entries invalid, occupancy 0, capacity 64; no clearing pass.
module lfu_replacement_directory_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    lfu_dir_req_if.sink                    req,
    lfu_dir_rsp_if.source                  rsp,
    input  logic                           cfg_we,
    input  logic [lfu_dir_pkg::CFG_W-1:0]  cfg_wdata
);

    lfu_dir_pkg::state_t  state_reg, state_next;

    lfu_dir_pkg::key_t    key_reg;
    lfu_dir_pkg::action_t action_reg;
    lfu_dir_pkg::cfg_t    cap_reg;
    lfu_dir_pkg::occ_t    occ_reg;
    logic [lfu_dir_pkg::ENTRIES-1:0] valid_reg;

    // Walk sequencer
    lfu_dir_pkg::idx_t    addr_reg;
    logic                 issued_all_reg;
    logic                 pipe_vld_reg;
    logic                 pipe_last_reg;
    lfu_dir_pkg::idx_t    pipe_addr_reg;

    // Entry memories
    lfu_dir_pkg::key_t    key_mem   [lfu_dir_pkg::ENTRIES];
    lfu_dir_pkg::count_t  count_mem [lfu_dir_pkg::ENTRIES];
    lfu_dir_pkg::idx_t    rec_mem   [lfu_dir_pkg::ENTRIES];
    lfu_dir_pkg::key_t    key_rd_reg;
    lfu_dir_pkg::count_t  count_rd_reg;
    lfu_dir_pkg::idx_t    rec_rd_reg;

    // Scan findings
    logic                 match_found_reg;
    lfu_dir_pkg::idx_t    match_idx_reg;
    lfu_dir_pkg::count_t  match_count_reg;
    lfu_dir_pkg::idx_t    match_rec_reg;
    logic                 free_found_reg;
    lfu_dir_pkg::idx_t    free_idx_reg;
    logic                 vict_found_reg;
    lfu_dir_pkg::idx_t    vict_idx_reg;
    lfu_dir_pkg::count_t  vict_count_reg;
    lfu_dir_pkg::idx_t    vict_rec_reg;
    lfu_dir_pkg::key_t    vict_key_reg;

    // Plan for the rank walk and insert
    lfu_dir_pkg::idx_t    rank_ref_reg;
    logic                 touch_reg;
    lfu_dir_pkg::idx_t    touch_idx_reg;
    logic                 ins_pend_reg;
    lfu_dir_pkg::idx_t    ins_slot_reg;

    // Pending result
    logic                 res_hit_reg;
    lfu_dir_pkg::idx_t    res_slot_reg;
    lfu_dir_pkg::count_t  res_count_reg;
    logic                 res_ev_reg;
    lfu_dir_pkg::key_t    res_evk_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    lfu_dir_pkg::slot_t   out_slot_reg;
    lfu_dir_pkg::use_t    out_use_reg;
    logic                 out_ev_reg;
    lfu_dir_pkg::key_t    out_evk_reg;

    logic                 accept;
    logic                 issue;
    logic                 walk_done;
    logic                 out_load;
    logic                 known_action;
    logic                 need_evict;
    logic                 do_touch;
    logic                 do_remove;
    logic                 do_evict;
    logic                 do_insert;
    lfu_dir_pkg::idx_t    ins_slot;
    lfu_dir_pkg::count_t  bumped;
    lfu_dir_pkg::cmp_t    cap_eff;
    lfu_dir_pkg::cmp_t    cap_ext;

    logic                 key_we;
    logic                 count_we;
    lfu_dir_pkg::idx_t    count_waddr;
    lfu_dir_pkg::count_t  count_wdata;
    logic                 rec_we;
    lfu_dir_pkg::idx_t    rec_waddr;
    lfu_dir_pkg::idx_t    rec_wdata;

    assign accept    = req.valid && req.ready;
    assign walk_done = pipe_vld_reg && pipe_last_reg;
    assign out_load  = (state_reg == lfu_dir_pkg::ST_RESULT) && (!out_valid_reg || rsp.ready);

    // Decision made from the scan findings
    always_comb
    begin
        cap_ext = lfu_dir_pkg::CMP_W'(cap_reg);
        if (cap_ext == '0)
            cap_eff = lfu_dir_pkg::CMP_W'(1);
        else if (cap_ext > lfu_dir_pkg::CMP_W'(lfu_dir_pkg::ENTRIES))
            cap_eff = lfu_dir_pkg::CMP_W'(lfu_dir_pkg::ENTRIES);
        else
            cap_eff = cap_ext;

        need_evict = (lfu_dir_pkg::CMP_W'(occ_reg) >= cap_eff) && vict_found_reg;

        known_action = 1'b0;
        do_touch     = 1'b0;
        do_remove    = 1'b0;
        do_evict     = 1'b0;
        do_insert    = 1'b0;
        unique case (action_reg)
            lfu_dir_pkg::ACT_FIND:
            begin
                known_action = 1'b1;
                do_touch     = match_found_reg;
            end
            lfu_dir_pkg::ACT_ADD:
            begin
                known_action = 1'b1;
                do_touch     = match_found_reg;
                do_evict     = !match_found_reg && need_evict;
                do_insert    = !match_found_reg && (need_evict || free_found_reg);
            end
            lfu_dir_pkg::ACT_REMOVE:
            begin
                known_action = 1'b1;
                do_remove    = match_found_reg;
            end
            default:
            begin
                known_action = 1'b0;
            end
        endcase

        // The victim's slot is freed first, so the lowest free slot may be it
        if (do_evict && !(free_found_reg && (free_idx_reg < vict_idx_reg)))
            ins_slot = vict_idx_reg;
        else
            ins_slot = free_idx_reg;

        bumped = (match_count_reg < lfu_dir_pkg::COUNT_MAX) ?
                 match_count_reg + lfu_dir_pkg::COUNT_BITS'(1) : match_count_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfu_dir_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = lfu_dir_pkg::ST_SCAN;
            end
            lfu_dir_pkg::ST_SCAN:
            begin
                if (walk_done)
                    state_next = lfu_dir_pkg::ST_DECIDE;
            end
            lfu_dir_pkg::ST_DECIDE:
            begin
                priority if (do_touch || do_remove || do_evict)
                    state_next = lfu_dir_pkg::ST_RANK;
                else if (do_insert)
                    state_next = lfu_dir_pkg::ST_WRITE;
                else
                    state_next = lfu_dir_pkg::ST_RESULT;
            end
            lfu_dir_pkg::ST_RANK:
            begin
                if (walk_done)
                    state_next = ins_pend_reg ? lfu_dir_pkg::ST_WRITE : lfu_dir_pkg::ST_RESULT;
            end
            lfu_dir_pkg::ST_WRITE:
            begin
                state_next = lfu_dir_pkg::ST_RESULT;
            end
            lfu_dir_pkg::ST_RESULT:
            begin
                if (out_load)
                    state_next = lfu_dir_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lfu_dir_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and memory write controls
    always_comb
    begin
        req.ready       = (state_reg == lfu_dir_pkg::ST_IDLE);
        rsp.valid       = out_valid_reg;
        rsp.hit         = out_hit_reg;
        rsp.slot        = out_slot_reg;
        rsp.use_count   = out_use_reg;
        rsp.evicted     = out_ev_reg;
        rsp.evicted_key = out_evk_reg;

        issue = ((state_reg == lfu_dir_pkg::ST_SCAN) || (state_reg == lfu_dir_pkg::ST_RANK))
                && !issued_all_reg;

        key_we      = (state_reg == lfu_dir_pkg::ST_WRITE);
        count_we    = 1'b0;
        count_waddr = ins_slot_reg;
        count_wdata = '0;
        rec_we      = 1'b0;
        rec_waddr   = pipe_addr_reg;
        rec_wdata   = rec_rd_reg - lfu_dir_pkg::IDX_W'(1);

        unique case (state_reg)
            lfu_dir_pkg::ST_DECIDE:
            begin
                count_we    = do_touch;
                count_waddr = match_idx_reg;
                count_wdata = bumped;
            end
            lfu_dir_pkg::ST_RANK:
            begin
                if (pipe_vld_reg)
                begin
                    // Touched entry becomes the most recent; ranks above the gap drop
                    if (touch_reg && (pipe_addr_reg == touch_idx_reg))
                    begin
                        rec_we    = 1'b1;
                        rec_wdata = lfu_dir_pkg::IDX_W'(occ_reg - lfu_dir_pkg::OCC_W'(1));
                    end
                    else if (valid_reg[pipe_addr_reg] && (rec_rd_reg > rank_ref_reg))
                    begin
                        rec_we = 1'b1;
                    end
                end
            end
            lfu_dir_pkg::ST_WRITE:
            begin
                count_we  = 1'b1;
                rec_we    = 1'b1;
                rec_waddr = ins_slot_reg;
                rec_wdata = lfu_dir_pkg::IDX_W'(occ_reg);
            end
            default:
            begin
                count_we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lfu_dir_pkg::ST_IDLE;
            cap_reg         <= lfu_dir_pkg::CAP_RESET;
            occ_reg         <= '0;
            valid_reg       <= '0;
            addr_reg        <= '0;
            issued_all_reg  <= 1'b0;
            pipe_vld_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            vict_found_reg  <= 1'b0;
            touch_reg       <= 1'b0;
            ins_pend_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= issue;

            if (cfg_we)
                cap_reg <= cfg_wdata;

            if (accept || (state_reg == lfu_dir_pkg::ST_DECIDE))
            begin
                addr_reg       <= '0;
                issued_all_reg <= 1'b0;
            end
            else if (issue)
            begin
                addr_reg       <= addr_reg + lfu_dir_pkg::IDX_W'(1);
                issued_all_reg <= (addr_reg == lfu_dir_pkg::IDX_W'(lfu_dir_pkg::ENTRIES - 1));
            end

            if (accept)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                vict_found_reg  <= 1'b0;
            end
            else if ((state_reg == lfu_dir_pkg::ST_SCAN) && pipe_vld_reg)
            begin
                if (valid_reg[pipe_addr_reg] && (key_rd_reg == key_reg))
                    match_found_reg <= 1'b1;
                if (!valid_reg[pipe_addr_reg])
                    free_found_reg <= 1'b1;
                if (valid_reg[pipe_addr_reg])
                    vict_found_reg <= 1'b1;
            end

            if (state_reg == lfu_dir_pkg::ST_DECIDE)
            begin
                touch_reg    <= do_touch;
                ins_pend_reg <= do_insert;
                if (do_remove)
                begin
                    valid_reg[match_idx_reg] <= 1'b0;
                    occ_reg                  <= occ_reg - lfu_dir_pkg::OCC_W'(1);
                end
                else if (do_evict)
                begin
                    valid_reg[vict_idx_reg] <= 1'b0;
                    occ_reg                 <= occ_reg - lfu_dir_pkg::OCC_W'(1);
                end
            end

            if (state_reg == lfu_dir_pkg::ST_WRITE)
            begin
                valid_reg[ins_slot_reg] <= 1'b1;
                occ_reg                 <= occ_reg + lfu_dir_pkg::OCC_W'(1);
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Entry memories: one read address, one write address per memory
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[ins_slot_reg] <= key_reg;
        if (count_we)
            count_mem[count_waddr] <= count_wdata;
        if (rec_we)
            rec_mem[rec_waddr] <= rec_wdata;
        key_rd_reg   <= key_mem[addr_reg];
        count_rd_reg <= count_mem[addr_reg];
        rec_rd_reg   <= rec_mem[addr_reg];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= addr_reg;
        pipe_last_reg <= (addr_reg == lfu_dir_pkg::IDX_W'(lfu_dir_pkg::ENTRIES - 1));

        if (accept)
        begin
            key_reg    <= req.key;
            action_reg <= lfu_dir_pkg::action_t'(req.action);
        end

        if ((state_reg == lfu_dir_pkg::ST_SCAN) && pipe_vld_reg)
        begin
            if (valid_reg[pipe_addr_reg] && (key_rd_reg == key_reg) && !match_found_reg)
            begin
                match_idx_reg   <= pipe_addr_reg;
                match_count_reg <= count_rd_reg;
                match_rec_reg   <= rec_rd_reg;
            end
            if (!valid_reg[pipe_addr_reg] && !free_found_reg)
                free_idx_reg <= pipe_addr_reg;
            // Lowest count wins, lower recency rank breaks a tie
            if (valid_reg[pipe_addr_reg] &&
                (!vict_found_reg || (count_rd_reg < vict_count_reg) ||
                 ((count_rd_reg == vict_count_reg) && (rec_rd_reg < vict_rec_reg))))
            begin
                vict_idx_reg   <= pipe_addr_reg;
                vict_count_reg <= count_rd_reg;
                vict_rec_reg   <= rec_rd_reg;
                vict_key_reg   <= key_rd_reg;
            end
        end

        if (state_reg == lfu_dir_pkg::ST_DECIDE)
        begin
            rank_ref_reg  <= do_evict ? vict_rec_reg : match_rec_reg;
            touch_idx_reg <= match_idx_reg;
            ins_slot_reg  <= ins_slot;
            res_hit_reg   <= known_action && match_found_reg;
            if (known_action && match_found_reg)
                res_slot_reg <= match_idx_reg;
            else if (do_insert)
                res_slot_reg <= ins_slot;
            else
                res_slot_reg <= '0;
            res_count_reg <= do_touch ? bumped : '0;
            res_ev_reg    <= do_evict;
            res_evk_reg   <= do_evict ? vict_key_reg : '0;
        end

        if (out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_slot_reg <= lfu_dir_pkg::slot_field(res_slot_reg);
            out_use_reg  <= lfu_dir_pkg::use_field(res_count_reg);
            out_ev_reg   <= res_ev_reg;
            out_evk_reg  <= res_evk_reg;
        end
    end

    // Occupancy always equals the number of valid entries
    a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == lfu_dir_pkg::OCC_W'($countones(valid_reg)))
        else $error("occupancy out of step with valid entries");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.evicted))
        else $error("hit and eviction in one transaction");

    a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.evicted) |-> (rsp.evicted_key == '0))
        else $error("evicted_key set without eviction");

    // A new result only comes out of the result state
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lfu_dir_pkg::ST_RESULT))
        else $error("result loaded outside result state");

endmodule
